>>> rtl/vso_pkg.sv
// Shared types, constants and constant tables of the vibrato sine oscillator.
package vso_pkg;

    localparam int PHASE_BITS    = 32;
    localparam int SAMPLE_RATE   = 48000;
    localparam int SINE_IDX_BITS = 10;
    localparam int QTR_BITS      = SINE_IDX_BITS - 2;
    localparam int QTR_SIZE      = 1 << QTR_BITS;
    localparam int SAMPLE_W      = 16;
    localparam int MAG_W         = SAMPLE_W - 1;
    localparam int CFG_W         = 31;
    localparam int NOTE_W        = 7;
    localparam int NOTE_COUNT    = 1 << NOTE_W;
    localparam int MUL_A_W       = 31;
    localparam int MUL_B_W       = 23;
    localparam int MUL_P_W       = MUL_A_W + MUL_B_W;

    localparam logic [CFG_W-1:0] CFG_RESET = 31'd536871;

    // Divide by 127 as multiply by ceil(2^37/127) and shift; exact for x < 2^23.
    localparam int DIV127_SHIFT = 37;
    localparam logic [MUL_A_W-1:0] DIV127_RECIP =
        MUL_A_W'((64'd1 << DIV127_SHIFT) / 64'd127 + 64'd1);
    localparam int ROUND_HALF = 63;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_NOTE_ON  = 2'd1,
        OP_NOTE_OFF = 2'd2,
        OP_END      = 2'd3
    } op_t;

    typedef enum logic {
        REG_VIB_STEP = 1'b0,
        REG_DEV_STEP = 1'b1
    } reg_idx_t;

    typedef logic [QTR_BITS:0]      qidx_t;
    typedef logic [MAG_W-1:0]       qtab_t [QTR_SIZE];
    typedef logic [PHASE_BITS-1:0]  note_tab_t [NOTE_COUNT];

    localparam logic [63:0] SEMITONE_Q30 [12] = '{
        64'd1073741824, 64'd1137589836, 64'd1205234447, 64'd1276901417,
        64'd1352829926, 64'd1433273380, 64'd1518500250, 64'd1608794974,
        64'd1704458901, 64'd1805811301, 64'd1913190429, 64'd2026954652
    };

    localparam logic [63:0] SIN_C1 = 64'd1686629713;
    localparam logic [63:0] SIN_C3 = 64'd693598669;
    localparam logic [63:0] SIN_C5 = 64'd85569306;
    localparam logic [63:0] SIN_C7 = 64'd5026995;
    localparam logic [63:0] SIN_C9 = 64'd172272;

    // Quarter-wave sine in Q15 for mirrored index rr (odd degree-9 polynomial, Q30 Horner).
    function automatic logic [MAG_W-1:0] sine_quarter(int unsigned rr);
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] p;
        logic [63:0] s;
        t  = 64'(rr) << (32 - SINE_IDX_BITS);
        t2 = (t * t) >> 30;
        p  = SIN_C9;
        p  = SIN_C7 - ((t2 * p) >> 30);
        p  = SIN_C5 - ((t2 * p) >> 30);
        p  = SIN_C3 - ((t2 * p) >> 30);
        p  = SIN_C1 - ((t2 * p) >> 30);
        s  = (t * p) >> 30;
        s  = (s + 64'd16384) >> 15;
        if (s > 64'd32767) begin
            s = 64'd32767;
        end
        return MAG_W'(s);
    endfunction

    function automatic qtab_t gen_qtab();
        qtab_t tab;
        for (int i = 0; i < QTR_SIZE; i++) begin
            tab[i] = sine_quarter(i);
        end
        return tab;
    endfunction

    // Equal-temperament phase step, 440 Hz at note 69, rounded half up.
    function automatic logic [PHASE_BITS-1:0] note_step_of(int unsigned note);
        int unsigned n;
        int unsigned oct;
        int unsigned semi;
        int          sh;
        logic [63:0] num;
        logic [63:0] q;
        n    = note + 3;
        oct  = n / 12;
        semi = n % 12;
        num  = 64'd440 * SEMITONE_Q30[semi];
        sh   = PHASE_BITS + int'(oct) - 36;
        if (sh >= 0) begin
            q = ((num << sh) + 64'(SAMPLE_RATE / 2)) / 64'(SAMPLE_RATE);
        end
        else begin
            q = ((num + (64'(SAMPLE_RATE) << (-sh - 1))) / 64'(SAMPLE_RATE)) >> (-sh);
        end
        return PHASE_BITS'(q);
    endfunction

    function automatic note_tab_t gen_note_tab();
        note_tab_t tab;
        for (int i = 0; i < NOTE_COUNT; i++) begin
            tab[i] = note_step_of(i);
        end
        return tab;
    endfunction

    localparam qtab_t             QTR_TAB      = gen_qtab();
    localparam logic [MAG_W-1:0]  QTR_PEAK     = sine_quarter(QTR_SIZE);
    localparam note_tab_t         NOTE_STEP_TAB = gen_note_tab();

endpackage

>>> rtl/vso_sine.sv
// Sine lookup: quarter-wave table with mirroring, magnitude and sign out.
module vso_sine (
    input  logic [vso_pkg::PHASE_BITS-1:0] phase,
    output logic [vso_pkg::MAG_W-1:0]      mag,
    output logic                           neg
);

    logic [vso_pkg::SINE_IDX_BITS-1:0] idx;
    logic [1:0]                        quarter;
    vso_pkg::qidx_t                    r;
    vso_pkg::qidx_t                    rr;

    always_comb
    begin
        idx     = phase[vso_pkg::PHASE_BITS-1 -: vso_pkg::SINE_IDX_BITS];
        quarter = idx[vso_pkg::SINE_IDX_BITS-1 -: 2];
        r       = vso_pkg::qidx_t'(idx[vso_pkg::QTR_BITS-1:0]);
        // mirror the falling quarters
        rr      = quarter[0] ? vso_pkg::qidx_t'(vso_pkg::QTR_SIZE) - r : r;
        mag     = rr[vso_pkg::QTR_BITS] ? vso_pkg::QTR_PEAK
                                        : vso_pkg::QTR_TAB[rr[vso_pkg::QTR_BITS-1:0]];
        neg     = quarter[1];
    end

endmodule

>>> rtl/vso_mul.sv
// Shared unsigned multiplier with registered product.
module vso_mul (
    input  logic                          clk,
    input  logic                          en,
    input  logic [vso_pkg::MUL_A_W-1:0]   a,
    input  logic [vso_pkg::MUL_B_W-1:0]   b,
    output logic [vso_pkg::MUL_P_W-1:0]   prod_reg
);

    logic [vso_pkg::MUL_P_W-1:0] prod_next;

    assign prod_next = vso_pkg::MUL_P_W'(a) * vso_pkg::MUL_P_W'(b);

    always_ff @(posedge clk)
    begin
        if (en) begin
            prod_reg <= prod_next;
        end
    end

endmodule

>>> rtl/vso_apb.sv
// APB register file: vibrato rate and deviation steps.
module vso_apb (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output logic [vso_pkg::CFG_W-1:0]   vib_step_reg,
    output logic [vso_pkg::CFG_W-1:0]   dev_step_reg
);

    logic              wr;
    vso_pkg::reg_idx_t sel;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign sel    = vso_pkg::reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vib_step_reg <= vso_pkg::CFG_RESET;
            dev_step_reg <= vso_pkg::CFG_RESET;
        end
        else if (wr) begin
            unique case (sel)
                vso_pkg::REG_VIB_STEP: vib_step_reg <= pwdata[vso_pkg::CFG_W-1:0];
                vso_pkg::REG_DEV_STEP: dev_step_reg <= pwdata[vso_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            vso_pkg::REG_VIB_STEP: prdata = {1'b0, vib_step_reg};
            vso_pkg::REG_DEV_STEP: prdata = {1'b0, dev_step_reg};
            default:               prdata = 32'd0;
        endcase
    end

endmodule

>>> rtl/vibrato_sine_oscillator.sv
// Top level: DDS sine oscillator with sinusoidal vibrato, shared-multiplier sequencer.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+---------------------------------
//  in       | sink      | in_valid / in_stall    | operation, note_number, velocity
//  out      | source    | out_valid / out_stall  | sample
//  apb      | slave     | psel/penable/pready    | paddr, pwdata, prdata
//
// Note on, note off and end finish in the accept step. A silent tick runs accept, then
// the output write; a sounding tick runs accept, vibrato sine times deviation, phase
// update, carrier sine times amplitude, divide by 127 (products on the shared multiplier),
// then the output register write. The in side stalls until the beat is back in idle.
// Reset clears phases, note step, amplitude, sounding and the output valid.
// A full, stalled output register holds the sequencer in its output step.
module vibrato_sine_oscillator (
    input  logic        clk,
    input  logic        rst_n,
    // input beats
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [6:0]  note_number,
    input  logic [6:0]  velocity,
    // output beats
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] sample,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_VIB  = 6'b000010,
        S_CAR  = 6'b000100,
        S_AMP  = 6'b001000,
        S_DIV  = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t                               state_reg;
    logic [vso_pkg::PHASE_BITS-1:0]       carrier_phase_reg;
    logic [vso_pkg::PHASE_BITS-1:0]       vibrato_phase_reg;
    logic [vso_pkg::PHASE_BITS-1:0]       note_step_reg;
    logic [vso_pkg::NOTE_W-1:0]           amplitude_reg;
    logic                                 sounding_reg;
    logic                                 vneg_reg;     // vibrato sine sign
    logic                                 cneg_reg;     // carrier sine sign
    logic                                 zero_reg;     // silent tick
    logic                                 out_valid_reg;
    logic [vso_pkg::SAMPLE_W-1:0]         sample_reg;

    logic [vso_pkg::CFG_W-1:0]            vib_step_reg;
    logic [vso_pkg::CFG_W-1:0]            dev_step_reg;

    logic                                 in_acc;
    logic                                 out_free;
    logic [vso_pkg::PHASE_BITS-1:0]       sine_phase;
    logic [vso_pkg::MAG_W-1:0]            sine_mag;
    logic                                 sine_neg;
    logic                                 mul_en;
    logic [vso_pkg::MUL_A_W-1:0]          mul_a;
    logic [vso_pkg::MUL_B_W-1:0]          mul_b;
    logic [vso_pkg::MUL_P_W-1:0]          prod_reg;
    logic [45:0]                          dev_mag;
    logic [46:0]                          dev_up;
    logic [vso_pkg::PHASE_BITS-1:0]       inc;
    logic [vso_pkg::PHASE_BITS-1:0]       carrier_next;
    logic [vso_pkg::SAMPLE_W-1:0]         quot;
    logic [vso_pkg::SAMPLE_W-1:0]         sample_next;

    vso_apb u_apb (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .vib_step_reg (vib_step_reg),
        .dev_step_reg (dev_step_reg)
    );

    // One sine lookup serves both oscillators: vibrato first, then carrier.
    assign sine_phase = (state_reg == S_VIB) ? vibrato_phase_reg : carrier_phase_reg;

    vso_sine u_sine (
        .phase (sine_phase),
        .mag   (sine_mag),
        .neg   (sine_neg)
    );

    // Multiplier schedule:
    //   VIB: deviation step times |vibrato sine|
    //   AMP: amplitude times |carrier sine|
    //   DIV: (product + 63) times reciprocal of 127
    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        unique case (state_reg)
            S_VIB:
            begin
                mul_en = 1'b1;
                mul_a  = dev_step_reg;
                mul_b  = vso_pkg::MUL_B_W'(sine_mag);
            end
            S_AMP:
            begin
                mul_en = 1'b1;
                mul_a  = vso_pkg::MUL_A_W'(amplitude_reg);
                mul_b  = vso_pkg::MUL_B_W'(sine_mag);
            end
            S_DIV:
            begin
                mul_en = 1'b1;
                mul_a  = vso_pkg::DIV127_RECIP;
                mul_b  = vso_pkg::MUL_B_W'(prod_reg[21:0])
                         + vso_pkg::MUL_B_W'(vso_pkg::ROUND_HALF);
            end
            default: ;
        endcase
    end

    vso_mul u_mul (
        .clk      (clk),
        .en       (mul_en),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod_reg)
    );

    // Deviation increment: truncate toward zero when positive, round away when negative.
    always_comb
    begin
        dev_mag      = prod_reg[45:0];
        dev_up       = 47'(dev_mag) + 47'd32767;
        inc          = vneg_reg ? (vso_pkg::PHASE_BITS'(0) - dev_up[46:15])
                                : vso_pkg::PHASE_BITS'(dev_mag[45:15]);
        carrier_next = carrier_phase_reg + note_step_reg + inc;
    end

    // Quotient never exceeds 32767, so no saturation is needed on either sign.
    always_comb
    begin
        quot = prod_reg[vso_pkg::DIV127_SHIFT +: vso_pkg::SAMPLE_W];
        if (zero_reg) begin
            sample_next = '0;
        end
        else if (cneg_reg) begin
            sample_next = vso_pkg::SAMPLE_W'(0) - quot;
        end
        else begin
            sample_next = quot;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg         <= S_IDLE;
            carrier_phase_reg <= '0;
            vibrato_phase_reg <= '0;
            note_step_reg     <= '0;
            amplitude_reg     <= '0;
            sounding_reg      <= 1'b0;
        end
        else begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc) begin
                        unique case (vso_pkg::op_t'(operation))
                            vso_pkg::OP_TICK:
                            begin
                                state_reg <= sounding_reg ? S_VIB : S_OUT;
                            end
                            vso_pkg::OP_NOTE_ON:
                            begin
                                note_step_reg     <= vso_pkg::NOTE_STEP_TAB[note_number];
                                amplitude_reg     <= velocity;
                                carrier_phase_reg <= '0;
                                vibrato_phase_reg <= '0;
                                sounding_reg      <= 1'b1;
                            end
                            vso_pkg::OP_NOTE_OFF: ;
                            vso_pkg::OP_END:
                            begin
                                sounding_reg <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_VIB:
                begin
                    state_reg <= S_CAR;
                end
                S_CAR:
                begin
                    carrier_phase_reg <= carrier_next;
                    vibrato_phase_reg <= vibrato_phase_reg
                                         + vso_pkg::PHASE_BITS'(vib_step_reg);
                    state_reg         <= S_AMP;
                end
                S_AMP:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    // hold here until the output register can take the beat
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Raise the output beat from the output step, drop it once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_OUT && out_free) begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Datapath side registers, no reset needed.
    always_ff @(posedge clk)
    begin
        if (in_acc) begin
            zero_reg <= !sounding_reg;
        end
        if (state_reg == S_VIB) begin
            vneg_reg <= sine_neg;
        end
        if (state_reg == S_AMP) begin
            cneg_reg <= sine_neg;
        end
        if (state_reg == S_OUT && out_free) begin
            sample_reg <= sample_next;
        end
    end

    // A new output beat only ever comes from the output step.
    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("output beat raised outside the output step");

    // Carrier phase moves only in the update step or on a note on.
    a_carrier_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_CAR
         && !(in_acc && operation == vso_pkg::OP_NOTE_ON))
        |=> $stable(carrier_phase_reg))
        else $error("carrier phase changed outside its update step");

    // The sounding computation never runs for a silent voice.
    a_vib_sounding: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_VIB) |-> sounding_reg)
        else $error("vibrato step entered while silent");

endmodule
